// ----- sv/clsr_pkg.sv -----
// Shared constants and helpers for the combined LCG shuffle generator.
// No dependencies; the core and clsr_mcg_step take names from here by scope.
`default_nettype none

package clsr_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int WORD_W      = 31;
    localparam int WARM_STEPS  = TABLE_DEPTH + 8;
    localparam int CNT_W       = $clog2(WARM_STEPS);

    // Moduli are 2^31 - C, so a product folds as hi*C + lo.
    localparam logic [WORD_W-1:0] M_ONE = 31'd2147483563;
    localparam logic [WORD_W-1:0] M_TWO = 31'd2147483399;
    localparam logic [15:0]       A_ONE = 16'd40014;
    localparam logic [15:0]       A_TWO = 16'd40692;
    localparam logic [7:0]        C_ONE = 8'd85;
    localparam logic [7:0]        C_TWO = 8'd249;

    localparam logic [WORD_W-1:0] SEED_RESET = 31'd77777;
    localparam logic [WORD_W-1:0] DRAW_CAP   = 31'd2147483305;
    localparam longint            SLOT_DIV   = 64'd1 + (64'(M_ONE) - 64'd1) / TABLE_DEPTH;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]  t_idx;

    // Table slot picked by the previous output: y / SLOT_DIV, at most TABLE_DEPTH-1.
    function automatic t_idx slot_of(input t_word y);
        t_idx s;
        s = '0;
        for (int k = 1; k < TABLE_DEPTH; k++) begin
            if (64'(y) >= 64'(k) * SLOT_DIV) begin
                s = IDX_W'(k);
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- sv/clsr_req_if.sv -----
// Request channel: one item asks for one draw, optionally after a reseed.
// Depends on nothing.
`default_nettype none

interface clsr_req_if;
    logic valid;
    logic ready;
    logic reseed;

    modport source (output valid, output reseed, input ready);
    modport sink   (input valid, input reseed, output ready);
endinterface

`default_nettype wire

// ----- sv/clsr_draw_if.sv -----
// Result channel: one item carries one shuffled draw.
// Depends on nothing.
`default_nettype none

interface clsr_draw_if;
    logic        valid;
    logic        ready;
    logic [30:0] draw;

    modport source (output valid, output draw, input ready);
    modport sink   (input valid, input draw, output ready);
endinterface

`default_nettype wire

// ----- sv/combined_lcg_shuffle_rng_core.sv -----
// Combined two-generator random source with a shuffle table in RAM.
// Depends on clsr_pkg, clsr_req_if, clsr_draw_if, clsr_ram, clsr_mcg_step.
`default_nettype none

// Each request returns one draw in 1..2147483305; draw/2147483563 is the
// uniform value. A plain draw passes through the three-stage modular
// multiply and the table read-modify-write around it before the next
// request can be accepted; the result sits in an output register while
// the next request is taken. Reset reruns the warm-up from seed 77777 and
// a reseed request from seed_value: 40 steps of the first generator,
// during which no request is accepted. seed_value takes effect only at
// the next reseed, not at reset; 0 or values above 2147483562 act as 1.
module combined_lcg_shuffle_rng_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire logic [30:0] i_cfg_data,
    clsr_req_if.sink    i_req,
    clsr_draw_if.source o_draw
);

    localparam logic [2:0] ST_WARM_INIT  = 3'd0;
    localparam logic [2:0] ST_WARM_WAIT  = 3'd1;
    localparam logic [2:0] ST_IDLE       = 3'd2;
    localparam logic [2:0] ST_DRAW_ISSUE = 3'd3;
    localparam logic [2:0] ST_DRAW_WAIT  = 3'd4;
    localparam logic [2:0] ST_FINISH     = 3'd5;

    logic [2:0] r_state, n_state;
    clsr_pkg::t_word r_seed, r_g1, n_g1, r_g2, n_g2, r_last_out, n_last_out;
    clsr_pkg::t_word r_out_draw, n_out_draw;
    logic r_out_valid, n_out_valid;
    logic r_pend, n_pend;
    logic [clsr_pkg::CNT_W-1:0] r_cnt, n_cnt;
    clsr_pkg::t_idx r_slot, n_slot;

    clsr_pkg::t_word seed_ok, u1_z, u1_res, u2_res, rd_data, ram_wdata, y_draw;
    logic u1_in_vld, u2_in_vld, u1_vld, u2_vld;
    logic ram_we, ram_re;
    clsr_pkg::t_idx ram_waddr, slot_now;
    logic [31:0] diff, diff_wrap;

    assign seed_ok = (r_seed == '0 || r_seed > clsr_pkg::M_ONE - 31'd1) ? 31'd1 : r_seed;
    assign slot_now = clsr_pkg::slot_of(r_last_out);
    assign diff = 32'(rd_data) - 32'(u2_res);
    assign diff_wrap = diff + 32'(clsr_pkg::M_ONE - 31'd1);
    assign y_draw = (diff[31] || diff == '0) ? diff_wrap[30:0] : diff[30:0];

    assign u1_z = (r_state == ST_WARM_INIT) ? seed_ok :
                  (r_state == ST_WARM_WAIT) ? u1_res : r_g1;
    assign u1_in_vld = (r_state == ST_WARM_INIT) || (r_state == ST_DRAW_ISSUE) ||
                       (r_state == ST_WARM_WAIT && u1_vld && r_cnt != '0);
    assign u2_in_vld = (r_state == ST_DRAW_ISSUE);

    clsr_mcg_step u_step_one (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sel_two(1'b0),
        .i_valid  (u1_in_vld),
        .i_z      (u1_z),
        .o_valid  (u1_vld),
        .o_result (u1_res)
    );

    clsr_mcg_step u_step_two (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sel_two(1'b1),
        .i_valid  (u2_in_vld),
        .i_z      (r_g2),
        .o_valid  (u2_vld),
        .o_result (u2_res)
    );

    assign ram_re    = (r_state == ST_DRAW_ISSUE);
    assign ram_we    = u1_vld && ((r_state == ST_DRAW_WAIT) ||
                       (r_state == ST_WARM_WAIT &&
                        r_cnt < clsr_pkg::CNT_W'(clsr_pkg::TABLE_DEPTH)));
    assign ram_waddr = (r_state == ST_DRAW_WAIT) ? r_slot : r_cnt[clsr_pkg::IDX_W-1:0];
    assign ram_wdata = u1_res;

    // Sequencing keeps the read of a slot and its write-back from overlapping.
    clsr_ram #(
        .WIDTH(clsr_pkg::WORD_W),
        .DEPTH(clsr_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(slot_now),
        .o_rdata(rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_g1        = r_g1;
        n_g2        = r_g2;
        n_last_out  = r_last_out;
        n_cnt       = r_cnt;
        n_slot      = r_slot;
        n_pend      = r_pend;
        n_out_draw  = r_out_draw;
        n_out_valid = r_out_valid && !o_draw.ready;

        unique case (r_state)
            ST_WARM_INIT: begin
                n_g1    = seed_ok;
                n_g2    = seed_ok;
                n_cnt   = clsr_pkg::CNT_W'(clsr_pkg::WARM_STEPS - 1);
                n_state = ST_WARM_WAIT;
            end
            ST_WARM_WAIT: begin
                if (u1_vld) begin
                    n_g1 = u1_res;
                    if (r_cnt == '0) begin
                        n_last_out = u1_res;
                        n_pend     = 1'b0;
                        n_state    = r_pend ? ST_DRAW_ISSUE : ST_IDLE;
                    end else begin
                        n_cnt = r_cnt - clsr_pkg::CNT_W'(1);
                    end
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_pend  = i_req.reseed;
                    n_state = i_req.reseed ? ST_WARM_INIT : ST_DRAW_ISSUE;
                end
            end
            ST_DRAW_ISSUE: begin
                n_slot  = slot_now;
                n_state = ST_DRAW_WAIT;
            end
            ST_DRAW_WAIT: begin
                if (u1_vld) begin
                    n_g1       = u1_res;
                    n_g2       = u2_res;
                    n_last_out = y_draw;
                    n_state    = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || o_draw.ready) begin
                    n_out_draw  = (r_last_out > clsr_pkg::DRAW_CAP) ?
                                  clsr_pkg::DRAW_CAP : r_last_out;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_WARM_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WARM_INIT;
            r_seed      <= clsr_pkg::SEED_RESET;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_seed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_g1       <= n_g1;
        r_g2       <= n_g2;
        r_last_out <= n_last_out;
        r_cnt      <= n_cnt;
        r_slot     <= n_slot;
        r_out_draw <= n_out_draw;
    end

    assign i_req.ready  = (r_state == ST_IDLE);
    assign o_draw.valid = r_out_valid;
    assign o_draw.draw  = r_out_draw;

    a_unit_result_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u1_vld |-> (r_state == ST_WARM_WAIT || r_state == ST_DRAW_WAIT))
        else $error("generator result arrived outside a wait state");

    a_units_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAW_WAIT && u1_vld) |-> u2_vld)
        else $error("generator units out of step during a draw");

    a_last_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_last_out != '0 && r_last_out < clsr_pkg::M_ONE))
        else $error("last output out of range");

    a_draw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_out_draw != '0 && r_out_draw <= clsr_pkg::DRAW_CAP))
        else $error("draw out of range");

endmodule

`default_nettype wire

// ----- sv/clsr_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
`default_nettype none

module clsr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/clsr_mcg_step.sv -----
// Three-stage modular multiply z*a mod (2^31 - c) for either generator.
// Depends on clsr_pkg.
`default_nettype none

module clsr_mcg_step (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_sel_two,
    input  wire logic          i_valid,
    input  wire clsr_pkg::t_word i_z,
    output logic               o_valid,
    output clsr_pkg::t_word    o_result
);

    logic [15:0] mult;
    logic [7:0]  fold_c;
    logic [30:0] modulus;

    logic        r_v1, r_v2, r_v3;
    logic [46:0] r_prod;
    logic [31:0] r_fold;
    clsr_pkg::t_word r_res;
    logic [31:0] fold_sub;

    assign mult    = i_sel_two ? clsr_pkg::A_TWO : clsr_pkg::A_ONE;
    assign fold_c  = i_sel_two ? clsr_pkg::C_TWO : clsr_pkg::C_ONE;
    assign modulus = i_sel_two ? clsr_pkg::M_TWO : clsr_pkg::M_ONE;
    assign fold_sub = r_fold - 32'(modulus);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Fold the high part back in: sum stays below twice the modulus.
    always_ff @(posedge i_clk) begin
        r_prod <= 47'(mult) * 47'(i_z);
        r_fold <= 32'(r_prod[46:31]) * 32'(fold_c) + 32'(r_prod[30:0]);
        r_res  <= (r_fold >= 32'(modulus)) ? fold_sub[30:0] : r_fold[30:0];
    end

    assign o_valid  = r_v3;
    assign o_result = r_res;

endmodule

`default_nettype wire
